/* rtl/etg_pkg.sv */
// ----------------------------------------------------------------------------
// etg_pkg: shared definitions for the enveloped tone generator
// Widths, constants, beat and command types, and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package etg_pkg;

  // Field widths
  localparam int SrW       = 16;  // sample rate register
  localparam int HzW       = 15;  // tone frequency
  localparam int MsW       = 16;  // note duration
  localparam int SampleW   = 15;  // output sample
  localparam int IdxW      = 22;  // sample counters
  localparam int FadeW     = 8;   // fade length
  localparam int EnvW      = 17;  // Q1.16 envelope and fade step
  localparam int MagW      = 15;  // sine magnitude, Q1.15 without sign
  localparam int AmpW      = 14;  // amplitude constant

  // Phase accumulator and sine table geometry
  localparam int PhaseBits = 32;
  localparam int SineDepth = 256;
  localparam int DepthBits = $clog2(SineDepth);
  localparam int TIdxW     = DepthBits + 1;
  localparam int PosW      = DepthBits + 2;
  localparam int QEntries  = SineDepth + 1;

  // Shared divider
  localparam int ProdW     = SrW + MsW;
  localparam int DivW      = HzW + PhaseBits;
  localparam int DivCntW   = $clog2(DivW + 1);
  localparam int RemW      = SrW + 1;

  // The constant divisions are reciprocal multiplies: x/200 is (x>>3)/25 and
  // x/1000 is (x>>3)/125, both exact over the operand ranges used here.
  localparam int RecipPreShift = 3;
  localparam int FadeRecipW    = 13;
  localparam int FadeShift     = 17;
  localparam int FadeQW        = SrW - RecipPreShift + FadeRecipW - FadeShift;
  localparam int LenRecipW     = 30;
  localparam int LenShift      = 36;
  localparam int LenQW         = ProdW - RecipPreShift + LenRecipW - LenShift;

  // Scaled sample product
  localparam int ScaleW     = EnvW + MagW + AmpW;
  localparam int ScaleShift = 31;

  localparam logic [SrW-1:0]        SrReset   = 16'd32000;
  localparam logic [FadeRecipW-1:0] FadeRecip = 13'd5243;
  localparam logic [LenRecipW-1:0]  LenRecip  = 30'd549755814;
  localparam logic [IdxW-1:0]       NoteMax   = 22'h3F_FFFF;
  localparam logic [FadeW-1:0]      FadeMax   = 8'hFF;
  localparam logic [EnvW-1:0]       EnvOne    = 17'h1_0000;
  localparam logic [AmpW-1:0]       Amplitude = 14'd16000;
  localparam logic [63:0]           HalfPiQ30 = 64'd1686629713;

  typedef enum logic {
    ActStart = 1'b0,
    ActTick  = 1'b1
  } action_e;

  typedef enum logic {
    OpPstep = 1'b0,
    OpFstep = 1'b1
  } div_op_e;

  typedef struct packed {
    action_e              action;
    logic [HzW-1:0]       tone_hz;
    logic [MsW-1:0]       length_ms;
  } etg_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_of_note;
  } etg_out_t;

  typedef struct packed {
    logic    capture;
    logic    prep;
    logic    div_load;
    div_op_e div_op;
    logic    div_store;
    logic    len_store;
    logic    note_load;
    logic    tick_load;
    logic    mul_en;
    logic    out_load;
  } etg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic busy;
    logic out_free;
  } etg_status_t;

  typedef logic [QEntries-1:0][MagW-1:0] quarter_t;

  // Quarter-wave table in Q1.15, built from a Q30 Taylor series of sin(x)
  // up to the x^11 term, rounded and saturated to 32767.
  function automatic quarter_t build_quarter();
    quarter_t    tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    int          k;
    for (k = 0; k < QEntries; k++) begin
      x    = (HalfPiQ30 * 64'(k)) / SineDepth;
      x2   = (x * x) >> 30;
      sum  = x;
      term = ((x * x2) >> 30) / 64'd6;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = (sum > term) ? sum - term : 64'd0;
      r    = (sum + 64'd16384) >> 15;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      tbl[k] = r[MagW-1:0];
    end
    return tbl;
  endfunction

  localparam quarter_t QuarterTable = build_quarter();

endpackage

`default_nettype wire

/* rtl/etg_div.sv */
// ----------------------------------------------------------------------------
// etg_div: shared restoring divider
// One quotient bit per cycle. The dividend arrives left-aligned and the
// iteration count equals its significant width. A zero divisor yields zero.
// ----------------------------------------------------------------------------
`default_nettype none

module etg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [etg_pkg::DivW-1:0]     dividend_i,
  input  logic [etg_pkg::SrW-1:0]      divisor_i,
  input  logic [etg_pkg::DivCntW-1:0]  iters_i,
  output logic                         done_o,
  output logic [etg_pkg::DivW-1:0]     quotient_o
);
  import etg_pkg::*;

  logic               active_q, active_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    quo_q;
  logic [RemW-1:0]    rem_q;
  logic [SrW-1:0]     div_q;
  logic [RemW-1:0]    rem_sh;
  logic [RemW-1:0]    rem_nx;
  logic               fits;
  logic               stepping;

  assign stepping = active_q && (cnt_q != '0);
  assign rem_sh   = {rem_q[RemW-2:0], quo_q[DivW-1]};
  assign fits     = rem_sh >= {1'b0, div_q};
  assign rem_nx   = fits ? (rem_sh - {1'b0, div_q}) : rem_sh;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (load_i) begin
      active_d = 1'b1;
      cnt_d    = iters_i;
    end else if (stepping) begin
      cnt_d = cnt_q - DivCntW'(1);
    end else if (active_q) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (stepping) begin
      quo_q <= {quo_q[DivW-2:0], fits};
      rem_q <= rem_nx;
    end
  end

  assign done_o     = active_q && (cnt_q == '0);
  assign quotient_o = (div_q == '0) ? '0 : quo_q;

endmodule

`default_nettype wire

/* rtl/etg_dp.sv */
// ----------------------------------------------------------------------------
// etg_dp: datapath of the enveloped tone generator
// Note parameters, phase accumulator, envelope, sine lookup, two-step
// scaling and the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module etg_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [etg_pkg::SrW-1:0]    cfg_data_i,
  input  etg_pkg::etg_in_t           in_data_i,
  input  etg_pkg::etg_cmd_t          cmd_i,
  output etg_pkg::etg_status_t       status_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output etg_pkg::etg_out_t          out_data_o
);
  import etg_pkg::*;

  // Configuration and captured start fields
  logic [SrW-1:0]   sr_q;
  logic [HzW-1:0]   hz_q;
  logic [MsW-1:0]   ms_q;
  logic [ProdW-1:0] lenp_q;
  div_op_e          op_q;

  // Note state
  logic [IdxW-1:0]      note_q;
  logic [FadeW-1:0]     fade_q;
  logic [EnvW-1:0]      fstep_q;
  logic [PhaseBits-1:0] pstep_q;
  logic [PhaseBits-1:0] phase_q;
  logic [IdxW-1:0]      index_q;
  logic                 is_rest_q;
  logic                 busy_q;

  // Sample pipeline
  logic [EnvW-1:0]      env_q;
  logic [MagW-1:0]      smag_q;
  logic                 neg_q;
  logic                 last_q;
  logic [EnvW+MagW-1:0] prod_q;
  logic                 out_valid_q;
  etg_out_t             out_q;

  // Divider hookup
  logic [DivW-1:0]    dividend;
  logic [SrW-1:0]     divisor;
  logic [DivCntW-1:0] iters;
  logic               div_done;
  logic [DivW-1:0]    quot;
  logic [ProdW-1:0]   len_prod;

  assign len_prod = sr_q * ms_q;

  always_comb begin
    unique case (cmd_i.div_op)
      OpPstep: begin
        dividend = {hz_q, {PhaseBits{1'b0}}};
        divisor  = sr_q;
        iters    = DivCntW'(DivW);
      end
      OpFstep: begin
        dividend = {EnvOne, {(DivW-EnvW){1'b0}}};
        divisor  = {{(SrW-FadeW){1'b0}}, fade_q};
        iters    = DivCntW'(EnvW);
      end
      default: begin
        dividend = '0;
        divisor  = '0;
        iters    = '0;
      end
    endcase
  end

  etg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.div_load),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .iters_i    (iters),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Fade length and note length by reciprocal multiplication
  logic [SrW-RecipPreShift+FadeRecipW-1:0]  fade_prod;
  logic [FadeQW-1:0]                        fade_quo;
  logic [FadeW-1:0]                         fade_sat;
  logic [ProdW-RecipPreShift+LenRecipW-1:0] len_mul;
  logic [LenQW-1:0]                         len_quo;
  logic [IdxW-1:0]                          note_sat;

  assign fade_prod = sr_q[SrW-1:RecipPreShift] * FadeRecip;
  assign fade_quo  = fade_prod[FadeShift +: FadeQW];
  assign fade_sat  = (fade_quo > FadeQW'(FadeMax)) ? FadeMax : fade_quo[FadeW-1:0];
  assign len_mul   = lenp_q[ProdW-1:RecipPreShift] * LenRecip;
  assign len_quo   = len_mul[LenShift +: LenQW];
  assign note_sat  = (len_quo > LenQW'(NoteMax)) ? NoteMax : len_quo[IdxW-1:0];

  // Envelope and sine lookup for the current sample
  logic [IdxW-1:0]       remain;
  logic [IdxW-1:0]       idx_next;
  logic [IdxW-1:0]       fade_ext;
  logic                  in_up;
  logic                  in_down;
  logic [FadeW-1:0]      env_n;
  logic [EnvW+FadeW-1:0] env_prod;
  logic [EnvW-1:0]       env_d;
  logic [PosW-1:0]       pos;
  logic [DepthBits-1:0]  kpos;
  logic [1:0]            quad;
  logic [TIdxW-1:0]      tidx;

  assign remain   = note_q - index_q;
  assign idx_next = index_q + IdxW'(1);
  assign fade_ext = {{(IdxW-FadeW){1'b0}}, fade_q};
  assign in_up    = index_q < fade_ext;
  assign in_down  = remain < fade_ext;
  assign env_n    = in_up ? index_q[FadeW-1:0] : remain[FadeW-1:0];
  assign env_prod = env_n * fstep_q;

  always_comb begin
    if (is_rest_q) begin
      env_d = '0;
    end else if (in_up || in_down) begin
      env_d = env_prod[EnvW-1:0];
    end else begin
      env_d = EnvOne;
    end
  end

  assign pos  = phase_q[PhaseBits-1 -: PosW];
  assign kpos = pos[DepthBits-1:0];
  assign quad = pos[PosW-1 -: 2];
  // Odd quadrants walk the quarter table backward.
  assign tidx = quad[0] ? (TIdxW'(SineDepth) - {1'b0, kpos}) : {1'b0, kpos};

  // Final scaling
  logic [ScaleW-1:0]  scaled;
  logic [SampleW-1:0] mag;

  assign scaled = prod_q * Amplitude;
  assign mag    = scaled[ScaleShift +: SampleW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q        <= SrReset;
      note_q      <= '0;
      fade_q      <= '0;
      fstep_q     <= '0;
      pstep_q     <= '0;
      phase_q     <= '0;
      index_q     <= '0;
      is_rest_q   <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sr_q <= cfg_data_i;
      end
      if (cmd_i.prep) begin
        fade_q <= fade_sat;
      end
      if (cmd_i.len_store) begin
        note_q <= note_sat;
      end
      if (cmd_i.div_store) begin
        unique case (op_q)
          OpPstep: pstep_q <= quot[PhaseBits-1:0];
          OpFstep: fstep_q <= quot[EnvW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.note_load) begin
        phase_q   <= '0;
        index_q   <= '0;
        is_rest_q <= (hz_q == '0);
        busy_q    <= (note_q != '0);
      end
      if (cmd_i.tick_load) begin
        phase_q <= phase_q + pstep_q;
        index_q <= idx_next;
        if (idx_next == note_q) begin
          busy_q <= 1'b0;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hz_q <= in_data_i.tone_hz;
      ms_q <= in_data_i.length_ms;
    end
    if (cmd_i.prep) begin
      lenp_q <= len_prod;
    end
    if (cmd_i.div_load) begin
      op_q <= cmd_i.div_op;
    end
    if (cmd_i.tick_load) begin
      env_q  <= env_d;
      smag_q <= QuarterTable[tidx];
      neg_q  <= quad[1];
      last_q <= (idx_next == note_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= env_q * smag_q;
    end
    if (cmd_i.out_load) begin
      out_q.sample       <= neg_q ? -$signed(mag) : $signed(mag);
      out_q.last_of_note <= last_q;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.busy     = busy_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/etg_ctrl.sv */
// ----------------------------------------------------------------------------
// etg_ctrl: controller of the enveloped tone generator
// Sequences the setup and the two divisions of a start and the three steps
// of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module etg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  etg_pkg::action_e      action_i,
  input  etg_pkg::etg_status_t  status_i,
  output etg_pkg::etg_cmd_t     cmd_o,
  output logic                  in_stall_o
);
  import etg_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b00_0001,
    StPrep  = 6'b00_0010,
    StPstep = 6'b00_0100,
    StFstep = 6'b00_1000,
    StMul   = 6'b01_0000,
    StOut   = 6'b10_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (action_i == ActStart) begin
            cmd_o.capture = 1'b1;
            state_d       = StPrep;
          end else if (status_i.busy) begin
            cmd_o.tick_load = 1'b1;
            state_d         = StMul;
          end
        end
      end
      StPrep: begin
        // The captured tone and duration are valid from this cycle on.
        cmd_o.prep     = 1'b1;
        cmd_o.div_load = 1'b1;
        cmd_o.div_op   = OpPstep;
        state_d        = StPstep;
      end
      StPstep: begin
        // The fade length is already stored, so its reciprocal can start.
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          cmd_o.len_store = 1'b1;
          cmd_o.div_load  = 1'b1;
          cmd_o.div_op    = OpFstep;
          state_d         = StFstep;
        end
      end
      StFstep: begin
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          cmd_o.note_load = 1'b1;
          state_d         = StIdle;
        end
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StOut;
      end
      StOut: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/enveloped_tone_generator.sv */
// ----------------------------------------------------------------------------
// enveloped_tone_generator: sine tone with a linear fade in and fade out
//
//   Channel | Direction | Handshake          | Beat
//   --------+-----------+--------------------+---------------------------
//   in      | input     | in_valid_i/_stall_o  | etg_in_t (action, tone, ms)
//   out     | output    | out_valid_o/_stall_i | etg_out_t (sample, last)
//   cfg     | input     | cfg_we_i           | sample_rate, 16 bits
//
// A start beat is accepted, then a setup step prepares the fade and note
// lengths, then two divisions run on the shared one-bit-per-cycle divider.
// A tick beat does the envelope and table lookup, then two multiplies.
// A tick waits in its last cycle while the previous sample is stalled; the
// output register lets the next beat be accepted while a sample waits.
// Reset is asynchronous and active low; the sine table is a constant.
// ----------------------------------------------------------------------------
`default_nettype none

module enveloped_tone_generator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [etg_pkg::SrW-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  etg_pkg::etg_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output etg_pkg::etg_out_t        out_data_o
);
  import etg_pkg::*;

  etg_cmd_t    cmd;
  etg_status_t status;

  etg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_data_i.action),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  etg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/etg_checker.sv */
// ----------------------------------------------------------------------------
// etg_checker: port-level checks for the enveloped tone generator
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module etg_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input etg_pkg::etg_in_t         in_data_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input etg_pkg::etg_out_t        out_data_o
);
  import etg_pkg::*;

  logic start_acc;

  assign start_acc = in_valid_i && !in_stall_o && (in_data_i.action == ActStart);

  // A start keeps the input side busy through the setup step and into the first division.
  a_start_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input accepted too soon after a start beat");

  // No tick can be in flight when a start is taken, so no sample appears.
  a_start_no_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> !$rose(out_valid_o))
    else $error("sample produced right after a start beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

endmodule

bind enveloped_tone_generator etg_checker u_etg_checker (.*);

`default_nettype wire
